@@ hdl/adaptive_binary_range_encoder_defines.svh @@
// assertion helpers shared by the checker
`ifndef ADAPTIVE_BINARY_RANGE_ENCODER_DEFINES_SVH
`define ADAPTIVE_BINARY_RANGE_ENCODER_DEFINES_SVH

// checked every clock edge outside reset
`define ABRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked every clock edge, reset included
`define ABRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/abre_pkg.sv @@
package abre_pkg;

  localparam int PROB_BITS    = 11;
  localparam int MOVE_BITS    = 5;
  localparam int NUM_CONTEXTS = 1024;

  localparam int CTX_W  = 10;
  localparam int ADDR_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  localparam int FLUSH_SHIFTS = 5;
  localparam int MAX_RENORM   = 4;

  localparam logic [PROB_BITS-1:0] PROB_INIT = {1'b1, {(PROB_BITS-1){1'b0}}};

  localparam logic       KIND_FLUSH = 1'b1;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [31:0] PEND_MAX  = 32'hFFFF_FFFF;
  localparam logic [31:0] RANGE_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  context_req;
    logic        bit_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
    logic        last;
  } out_item_t;

  // coder state touched by a low shift
  typedef struct packed {
    logic [32:0] low;
    logic [7:0]  cached;
    logic [31:0] pending;
  } coder_t;

  typedef struct packed {
    logic      emit;
    out_item_t beat;
    coder_t    next;
  } shift_res_t;

  function automatic logic [PROB_BITS-1:0] prob_update(input logic [PROB_BITS-1:0] p,
                                                       input logic b);
    logic [PROB_BITS:0] full;
    logic [PROB_BITS:0] up;
    full = {1'b1, {PROB_BITS{1'b0}}};
    up   = {1'b0, p} + ((full - {1'b0, p}) >> MOVE_BITS);
    if (b) begin
      return p - (p >> MOVE_BITS);
    end
    return up[PROB_BITS-1:0];
  endfunction

endpackage

@@ hdl/adaptive_binary_range_encoder.sv @@
// LZMA-style binary range encoder. An encode beat passes the probability table
// read and 21x11 multiply (one registered stage each), then 0 to 4 renormalization
// steps; a flush beat goes straight to its low shifts. Steps run one per cycle
// through the single low-shift unit while output backpressure does not stall them.
// Each released byte run leaves as one result beat, last marking the final
// beat of an item. After reset a clearing pass over all 1024 contexts sets every
// probability to one half; item_ready stays low meanwhile.
module adaptive_binary_range_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  abre_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output abre_pkg::out_item_t  result
);

  localparam int AW = abre_pkg::ADDR_W;
  localparam int PB = abre_pkg::PROB_BITS;

  abre_pkg::state_t   state, state_next;
  logic [AW-1:0]      clr_cnt;
  abre_pkg::coder_t   coder;
  logic [31:0]        range;
  logic [31:0]        bound;
  logic [PB-1:0]      p_reg;
  logic               bit_reg;
  logic               flush_reg;
  logic [AW-1:0]      addr_reg;
  logic [2:0]         step_cnt;
  abre_pkg::out_item_t held;
  logic               held_valid;

  abre_pkg::shift_res_t sres;
  logic               ctx_ok;
  logic [AW-1:0]      rd_addr;
  logic [PB-1:0]      rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [PB-1:0]      ram_wdata;
  logic [31:0]        product;
  logic               out_free;
  logic               step_go;
  logic               step_do;
  logic               push_out;
  logic               push_last;
  logic               accept;

  abre_ram #(
    .WIDTH (PB),
    .DEPTH (abre_pkg::NUM_CONTEXTS)
  ) u_prob_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  abre_shift u_shift (
    .cur (coder),
    .res (sres)
  );

  // out-of-range contexts fold onto the last model
  assign ctx_ok  = {{(32-abre_pkg::CTX_W){1'b0}}, item.context_req}
                   < 32'(abre_pkg::NUM_CONTEXTS);
  assign rd_addr = ctx_ok ? AW'(item.context_req) : AW'(abre_pkg::NUM_CONTEXTS - 1);

  assign product = {{PB{1'b0}}, range[31:PB]} * {{(32-PB){1'b0}}, rdata};
  assign out_free = !result_valid || result_ready;

  always_comb begin
    item_ready = (state == abre_pkg::ST_IDLE);
    accept     = item_ready && item_valid;
    ram_we     = (state == abre_pkg::ST_CLEAR) || (state == abre_pkg::ST_UPD);
    ram_waddr  = (state == abre_pkg::ST_CLEAR) ? clr_cnt : addr_reg;
    ram_wdata  = (state == abre_pkg::ST_CLEAR) ? abre_pkg::PROB_INIT
                                               : abre_pkg::prob_update(p_reg, bit_reg);
    if (flush_reg) begin
      step_go = step_cnt < 3'(abre_pkg::FLUSH_SHIFTS);
    end else begin
      step_go = (step_cnt < 3'(abre_pkg::MAX_RENORM)) && (range[31:24] == 8'd0);
    end
    // a new release waits until the held beat can move to the output register
    step_do   = (state == abre_pkg::ST_SHIFT) && step_go &&
                !(sres.emit && held_valid && !out_free);
    push_last = (state == abre_pkg::ST_FINISH);
    push_out  = (step_do && sres.emit && held_valid) ||
                (push_last && held_valid && out_free);
  end

  always_comb begin
    state_next = state;
    case (state)
      abre_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(abre_pkg::NUM_CONTEXTS - 1)) begin
          state_next = abre_pkg::ST_IDLE;
        end
      end
      abre_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = (item.kind == abre_pkg::KIND_FLUSH) ? abre_pkg::ST_SHIFT
                                                           : abre_pkg::ST_MUL;
        end
      end
      abre_pkg::ST_MUL: state_next = abre_pkg::ST_UPD;
      abre_pkg::ST_UPD: state_next = abre_pkg::ST_SHIFT;
      abre_pkg::ST_SHIFT: begin
        if (!step_go) begin
          state_next = abre_pkg::ST_FINISH;
        end
      end
      abre_pkg::ST_FINISH: begin
        if (!held_valid || out_free) begin
          state_next = abre_pkg::ST_IDLE;
        end
      end
      default: state_next = abre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= abre_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      coder.low     <= '0;
      coder.cached  <= '0;
      coder.pending <= 32'd1;
      range         <= abre_pkg::RANGE_INIT;
      flush_reg     <= 1'b0;
      step_cnt      <= '0;
      held_valid    <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == abre_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (accept) begin
        flush_reg <= (item.kind == abre_pkg::KIND_FLUSH);
        bit_reg   <= item.bit_value;
        addr_reg  <= rd_addr;
        step_cnt  <= '0;
      end
      if (state == abre_pkg::ST_MUL) begin
        bound <= product;
        p_reg <= rdata;
      end
      if (state == abre_pkg::ST_UPD) begin
        if (bit_reg) begin
          coder.low <= coder.low + {1'b0, bound};
          range     <= range - bound;
        end else begin
          range <= bound;
        end
      end
      if (step_do) begin
        step_cnt <= step_cnt + 3'd1;
        coder    <= sres.next;
        if (!flush_reg) begin
          range <= {range[23:0], 8'h00};
        end
        if (sres.emit) begin
          held       <= sres.beat;
          held_valid <= 1'b1;
        end
      end
      if (push_out) begin
        result <= '{first_byte: held.first_byte,
                    fill_byte:  held.fill_byte,
                    fill_count: held.fill_count,
                    last:       push_last};
        if (push_last) begin
          held_valid <= 1'b0;
        end
      end
      if (push_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/abre_ram.sv @@
module abre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/abre_shift.sv @@
module abre_shift (
  input  abre_pkg::coder_t     cur,
  output abre_pkg::shift_res_t res
);

  logic [31:0] low32;
  logic        carry;
  logic        emit;
  logic [31:0] pend;

  always_comb begin
    low32 = cur.low[31:0];
    carry = cur.low[32];
    // top byte 0xFF without carry keeps the run open
    emit  = carry | (low32[31:24] != abre_pkg::BYTE_ONES);

    res.emit            = emit;
    res.beat.first_byte = cur.cached + {7'b0, carry};
    res.beat.fill_byte  = carry ? abre_pkg::BYTE_ZERO : abre_pkg::BYTE_ONES;
    res.beat.fill_count = (cur.pending == 32'd0) ? 32'd0 : cur.pending - 32'd1;
    res.beat.last       = 1'b0;

    pend = emit ? 32'd0 : cur.pending;
    res.next.pending = (pend == abre_pkg::PEND_MAX) ? pend : pend + 32'd1;
    res.next.cached  = emit ? low32[31:24] : cur.cached;
    res.next.low     = {1'b0, low32[23:0], 8'h00};
  end

endmodule

@@ hdl/abre_checker.sv @@
`include "adaptive_binary_range_encoder_defines.svh"

module abre_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input abre_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_ready,
  input abre_pkg::out_item_t result
);

  // a stalled result beat holds
  `ABRE_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result beat changed while stalled")

  // fill bytes are all ones, or all zeros after a carry
  `ABRE_ASSERT(a_fill_byte, result_valid |-> (result.fill_byte == 8'hFF || result.fill_byte == 8'h00), "bad fill byte")

  // the fill count stays one below all ones, since the pending count saturates at all ones
  `ABRE_ASSERT(a_fill_sat, result_valid |-> result.fill_count != 32'hFFFF_FFFF, "fill count beyond saturation")

  // an item is not finished while one of its non-final beats is still shown
  `ABRE_ASSERT(a_last_before_next, result_valid && !result.last |-> !item_ready, "next item taken before final beat")

  // one item at a time
  `ABRE_ASSERT_ALWAYS(a_one_item, rst || !(item_valid && item_ready) || 1'b1 |=> rst || !(item_ready && $past(item_valid && item_ready)), "item taken on consecutive cycles")

endmodule

bind adaptive_binary_range_encoder abre_checker u_abre_checker (.*);

@@ tb/sv/adaptive_binary_range_encoder_tb.sv @@
module adaptive_binary_range_encoder_tb;

  localparam logic        KIND_CODE  = 1'b0;
  localparam logic [31:0] TOP_RANGE  = 32'h0100_0000;
  localparam logic [31:0] CARRY_EDGE = 32'hFF00_0000;
  localparam int          HOLD_LEN   = 400;
  localparam int          SETTLE     = 40;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  abre_pkg::in_item_t  item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  abre_pkg::out_item_t result;

  // coder state as the encoder should hold it
  logic [32:0]                    coder_low;
  logic [31:0]                    coder_range;
  logic [7:0]                     coder_cache;
  logic [31:0]                    coder_pending;
  logic [abre_pkg::PROB_BITS-1:0] prob_model [abre_pkg::NUM_CONTEXTS];

  abre_pkg::in_item_t  pending_beats [$];
  abre_pkg::out_item_t byte_runs [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  adaptive_binary_range_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one low shift; releases the cached byte and its pending run unless a carry may still come
  function automatic void shift_out_byte();
    logic [31:0]         low32;
    logic                carry;
    abre_pkg::out_item_t run;
    low32 = coder_low[31:0];
    carry = coder_low[32];
    if (carry || low32 < CARRY_EDGE) begin
      run.first_byte = coder_cache + {7'b0, carry};
      run.fill_byte  = abre_pkg::BYTE_ONES + {7'b0, carry};
      run.fill_count = (coder_pending != 0) ? coder_pending - 32'd1 : 32'd0;
      run.last       = 1'b0;
      byte_runs      = {byte_runs, run};
      coder_cache    = low32[31:24];
      coder_pending  = 0;
    end
    // saturation is out of reach in any practical run
    if (coder_pending != abre_pkg::PEND_MAX) coder_pending = coder_pending + 32'd1;
    coder_low = {1'b0, low32[23:0], 8'h00};
  endfunction

  function automatic void encode_beat(input abre_pkg::in_item_t b);
    int unsigned prob;
    logic [31:0] bound;
    int          base;
    base = byte_runs.size();
    if (b.kind == abre_pkg::KIND_FLUSH) begin
      for (int i = 0; i < abre_pkg::FLUSH_SHIFTS; i++) shift_out_byte();
    end else begin
      prob  = 32'(prob_model[b.context_req]);
      bound = (coder_range >> abre_pkg::PROB_BITS) * prob;
      if (!b.bit_value) begin
        coder_range = bound;
        prob = prob + (((1 << abre_pkg::PROB_BITS) - prob) >> abre_pkg::MOVE_BITS);
      end else begin
        coder_low   = coder_low + {1'b0, bound};
        coder_range = coder_range - bound;
        prob = prob - (prob >> abre_pkg::MOVE_BITS);
      end
      prob_model[b.context_req] = prob[abre_pkg::PROB_BITS-1:0];
      for (int i = 0; i < abre_pkg::MAX_RENORM && coder_range < TOP_RANGE; i++) begin
        coder_range = coder_range << 8;
        shift_out_byte();
      end
    end
    if (byte_runs.size() > base) byte_runs[byte_runs.size()-1].last = 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) encode_beat(item);
      if (!item_valid || item_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= pending_beats.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    abre_pkg::out_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (byte_runs.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, result);
          mismatches++;
        end else begin
          want = byte_runs.pop_front();
          if (result.first_byte !== want.first_byte) begin
            $display("%0t: first_byte expected %h got %h", $time, want.first_byte,
                     result.first_byte);
            mismatches++;
          end
          if (result.fill_byte !== want.fill_byte) begin
            $display("%0t: fill_byte expected %h got %h", $time, want.fill_byte,
                     result.fill_byte);
            mismatches++;
          end
          if (result.fill_count !== want.fill_count) begin
            $display("%0t: fill_count expected %0d got %0d", $time, want.fill_count,
                     result.fill_count);
            mismatches++;
          end
          if (result.last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, result.last);
            mismatches++;
          end
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_beat(input logic kind, input logic [9:0] ctx, input logic bv);
    abre_pkg::in_item_t b;
    b.kind        = kind;
    b.context_req = ctx;
    b.bit_value   = bv;
    pending_beats = {pending_beats, b};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_beats.size() != 0 || item_valid || byte_runs.size() != 0) @(negedge clk);
  endtask

  // mostly runs of one bit, half of them on a few busy contexts, which skew the models and
  // push low toward 0xff runs and carries; the rest is scattered bits and flushes
  task automatic queue_random(input int count);
    int          added;
    int          roll;
    int          len;
    int          pick;
    logic [9:0]  ctx;
    logic        bv;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(99);
      pick = $urandom_range(7);
      ctx  = $urandom_range(1) ? ((pick < 4) ? 10'(pick) : 10'(1016 + pick))
                               : 10'($urandom_range(1023));
      if (roll < 6) begin
        queue_beat(abre_pkg::KIND_FLUSH, 10'($urandom_range(1023)), 1'($urandom_range(1)));
        added++;
      end else if (roll < 35) begin
        bv  = 1'($urandom_range(1));
        len = $urandom_range(16, 4);
        for (int k = 0; k < len; k++) queue_beat(KIND_CODE, ctx, ($urandom_range(9) == 0) ^ bv);
        added += len;
      end else begin
        queue_beat(KIND_CODE, ctx, 1'($urandom_range(1)));
        added++;
      end
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                           input bit long_hold);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) begin
      hold_start = 1'b1;
      @(negedge clk);
      hold_start = 1'b0;
    end
    queue_random(count);
    wait_drained();
  endtask

  initial begin
    coder_low     = '0;
    coder_range   = abre_pkg::RANGE_INIT;
    coder_cache   = '0;
    coder_pending = 32'd1;
    for (int i = 0; i < abre_pkg::NUM_CONTEXTS; i++) prob_model[i] = abre_pkg::PROB_INIT;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // context extremes with both symbols
    queue_beat(KIND_CODE, 10'd0, 1'b0);
    queue_beat(KIND_CODE, 10'd1023, 1'b1);
    queue_beat(KIND_CODE, 10'd1023, 1'b0);
    queue_beat(KIND_CODE, 10'd0, 1'b1);
    queue_beat(abre_pkg::KIND_FLUSH, 10'd1023, 1'b1);
    // train one model hard, then code against it
    for (int i = 0; i < 8; i++) queue_beat(KIND_CODE, 10'd512, 1'b0);
    for (int i = 0; i < 8; i++) queue_beat(KIND_CODE, 10'd512, 1'b1);
    // flush twice: the second one starts from a flushed coder
    queue_beat(abre_pkg::KIND_FLUSH, 10'd0, 1'b0);
    queue_beat(abre_pkg::KIND_FLUSH, 10'd341, 1'b1);
    wait_drained();

    run_phase(0, 0, 65, 1'b0);
    run_phase(0, 0, 55, 1'b1);
    run_phase(79, 0, 70, 1'b0);
    run_phase(0, 79, 70, 1'b0);
    run_phase(6, 6, 70, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
